FILE: hw/rtl/xctr_pkg.sv
// shared types, constants and round-schedule functions for the xtea ctr cipher
`timescale 1ns / 1ps

package xctr_pkg;

	// cipher geometry
	localparam int unsigned ROUND_COUNT = 32;
	localparam int unsigned HALF_COUNT  = 2 * ROUND_COUNT;
	localparam int unsigned KEY_WORDS   = 4;

	localparam logic [31:0] DELTA = 32'h9E3779B9;

	// key words after reset
	localparam logic [31:0] KEY_RESET [KEY_WORDS] = '{
		32'hA6E31F4B, 32'hC904B27D, 32'h51D8A3E9, 32'h7B2F90C5
	};

	// key word index type
	typedef logic [1:0] key_idx_t;

	// word travelling down the round pipeline: p is the half updated next
	typedef struct packed {
		logic [31:0] p;
		logic [31:0] q;
		logic [63:0] data;
		logic [3:0]  count;
	} stage_t;

	// running sum used by half round j: even halves use the sum before the
	// delta step, odd halves the sum after it
	function automatic logic [31:0] hr_sum(input int unsigned j);
		logic [31:0] r;
		r = 32'((j + 1) >> 1);
		return DELTA * r;
	endfunction

	// key word selected by half round j
	function automatic key_idx_t hr_sel(input int unsigned j);
		logic [31:0] s;
		s = hr_sum(j);
		if (j[0] == 1'b0) begin
			return s[1:0];
		end
		return s[12:11];
	endfunction

	// xtea mixing function
	function automatic logic [31:0] mix(input logic [31:0] v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

endpackage

FILE: hw/rtl/xtea_ctr_block_cipher.sv
// top level: xtea counter-mode cipher, one 64-bit block per word
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_ready) carries one word: nonce_high, nonce_low,
//   block_index, data_block and byte_count. The counter block
//   {nonce_high ^ block_index, nonce_low + block_index} is enciphered with 32
//   xtea cycles and the keystream is xored into the leading byte_count bytes
//   (counts above eight act as eight, zero leaves the data as is).
//   Output channel (out_valid / out_ready) returns result_block and result_count.
//   Throughput: one word per cycle while the skid entry is free, set by the fully
//   unrolled round pipeline (one half round per stage, 64 stages). A word
//   passes the counter block stage, the round stages and the output register.
//   Key words are written through cfg_we / cfg_index / cfg_data while the block
//   holds no words; the new key applies to words accepted after the write.
//   Reset clears all pipeline valids and the output buffers and loads the
//   default key. When the receiver stalls, a two-entry output buffer (output
//   register plus skid) absorbs the pipeline, and in_ready drops only once
//   the skid entry is taken, so no word is lost or repeated.

module xtea_ctr_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] nonce_high,
	input  logic [31:0] nonce_low,
	input  logic [31:0] block_index,
	input  logic [63:0] data_block,
	input  logic [3:0]  byte_count,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_block,
	output logic [3:0]  result_count
);

	localparam int unsigned HALVES = xctr_pkg::HALF_COUNT;

	logic [31:0]      key_q [xctr_pkg::KEY_WORDS];
	logic [31:0]      rk_q  [HALVES];
	logic             en;
	logic             ctr_vld_s1;
	xctr_pkg::stage_t ctr_s1;
	logic             pipe_vld [HALVES + 1];
	xctr_pkg::stage_t pipe     [HALVES + 1];
	xctr_pkg::stage_t last;
	logic [63:0]      stream;
	logic [3:0]       n_bytes;
	logic [63:0]      mask;
	logic [63:0]      fin_block;
	logic             out_vld_q;
	logic [63:0]      out_block_q;
	logic [3:0]       out_count_q;
	logic             skid_vld_q;
	logic [63:0]      skid_block_q;
	logic [3:0]       skid_count_q;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < xctr_pkg::KEY_WORDS; i++) begin
				key_q[i] <= xctr_pkg::KEY_RESET[i];
			end
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	// per half round key plus running sum
	always_ff @(posedge clk) begin
		for (int j = 0; j < HALVES; j++) begin
			rk_q[j] <= xctr_pkg::hr_sum(j) + key_q[xctr_pkg::hr_sel(j)];
		end
	end

	// whole pipeline advances while the skid entry is free
	assign en       = !skid_vld_q;
	assign in_ready = en;

	// counter block stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_vld_s1 <= 1'b0;
		end else if (en) begin
			ctr_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctr_s1.p     <= nonce_high ^ block_index;
			ctr_s1.q     <= nonce_low + block_index;
			ctr_s1.data  <= data_block;
			ctr_s1.count <= byte_count;
		end
	end

	assign pipe_vld[0] = ctr_vld_s1;
	assign pipe[0]     = ctr_s1;

	// round stages
	for (genvar j = 0; j < HALVES; j++) begin : g_round
		xctr_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.rk        (rk_q[j]),
			.in_vld    (pipe_vld[j]),
			.in_stage  (pipe[j]),
			.out_vld   (pipe_vld[j + 1]),
			.out_stage (pipe[j + 1])
		);
	end

	// keystream and byte mask
	assign last    = pipe[HALVES];
	assign stream  = {last.p, last.q};
	assign n_bytes = (last.count > 4'd8) ? 4'd8 : last.count;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mask[63 - 8 * i -: 8] = (4'(i) < n_bytes) ? 8'hFF : 8'h00;
		end
	end

	assign fin_block = last.data ^ (stream & mask);

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !out_ready) begin
			if (en && pipe_vld[HALVES]) begin
				skid_vld_q <= 1'b1;
			end
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= en && pipe_vld[HALVES];
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !out_ready) begin
			if (en && pipe_vld[HALVES]) begin
				skid_block_q <= fin_block;
				skid_count_q <= last.count;
			end
		end else if (skid_vld_q) begin
			out_block_q <= skid_block_q;
			out_count_q <= skid_count_q;
		end else begin
			out_block_q <= fin_block;
			out_count_q <= last.count;
		end
	end

	assign out_valid    = out_vld_q;
	assign result_block = out_block_q;
	assign result_count = out_count_q;

	// skid entry is only ever occupied behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held with empty output register");

	// skid fills only when the receiver stalled a waiting word
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("skid filled without a stalled output word");

	// output cannot go empty while a skid word was pending
	a_no_drop_skid: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_vld_q) |-> !$past(skid_vld_q))
		else $error("output emptied while skid word pending");

	// a key write lands in the addressed word
	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> key_q[$past(cfg_index)] == $past(cfg_data))
		else $error("key word write lost");

endmodule

FILE: hw/rtl/xctr_round.sv
// one xtea half round as a pipeline stage
`timescale 1ns / 1ps

module xctr_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [31:0]         rk,
	input  logic                in_vld,
	input  xctr_pkg::stage_t    in_stage,
	output logic                out_vld,
	output xctr_pkg::stage_t    out_stage
);

	logic             vld_s;
	xctr_pkg::stage_t stage_s;
	xctr_pkg::stage_t stage_d;

	// feistel half step, halves swap so the next stage updates the other one
	always_comb begin
		stage_d       = in_stage;
		stage_d.p     = in_stage.q;
		stage_d.q     = in_stage.p + (xctr_pkg::mix(in_stage.q) ^ rk);
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= in_vld;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			stage_s <= stage_d;
		end
	end

	assign out_vld   = vld_s;
	assign out_stage = stage_s;

endmodule
